>>> hw/rtl/rcmv_pkg.sv
// rcmv_pkg: constants, widths and controller/datapath struct types for the rod cutting block
// no dependencies; used by rcmv_ctrl, rcmv_dp and rod_cutting_max_value_top
package rcmv_pkg;

	localparam int MAX_ROD    = 16;
	localparam int MAX_PIECE  = 16;
	localparam int PRICE_BITS = 16;

	localparam int LEN_W      = 5;
	localparam int IN_PRICE_W = 16;
	localparam int VALUE_BITS = 20;

	localparam int ROD_W  = $clog2(MAX_ROD + 1);
	localparam int K_W    = $clog2(MAX_PIECE + 1);
	localparam int PIDX_W = (MAX_PIECE > 1) ? $clog2(MAX_PIECE) : 1;
	localparam int CW     = (ROD_W > K_W) ? ROD_W : K_W;
	localparam int SUM_W  = ((PRICE_BITS > VALUE_BITS) ? PRICE_BITS : VALUE_BITS) + 1;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
	localparam logic [K_W-1:0]        KMAX_V    = K_W'(MAX_PIECE);
	localparam logic [ROD_W-1:0]      ROD_MAX_V = ROD_W'(MAX_ROD);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	typedef struct packed {
		logic load;
		logic start;
		logic dp_step;
		logic count_step;
		logic emit_step;
	} rcmv_cmd_t;

	typedef struct packed {
		logic dp_done;
		logic walk_end;
		logic out_free;
	} rcmv_sts_t;

endpackage

>>> hw/rtl/rcmv_ctrl.sv
// rcmv_ctrl: sequencer for load, table fill, piece count and piece emission
// depends on rcmv_pkg; drives rcmv_dp through rcmv_cmd_t, watches rcmv_sts_t
module rcmv_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        op,
	input  logic [rcmv_pkg::LEN_W-1:0]  piece_length,
	input  rcmv_pkg::rcmv_sts_t         sts,
	output rcmv_pkg::rcmv_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FILL  = 2'd1;
	localparam logic [1:0] ST_COUNT = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && op == rcmv_pkg::OP_LOAD) begin
					cmd.load = 1'b1;
				end else if (accept && op == rcmv_pkg::OP_SOLVE && piece_length != '0) begin
					cmd.start = 1'b1;
					state_d   = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.dp_step = 1'b1;
				if (sts.dp_done) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.count_step = 1'b1;
				if (sts.walk_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_step = 1'b1;
					if (sts.walk_end) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_start_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == ST_FILL)
		else $error("solve start did not enter table fill");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");
	a_emit_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step && sts.walk_end |=> in_ready)
		else $error("block not idle after last piece");
`endif

endmodule

>>> hw/rtl/rcmv_dp.sv
// rcmv_dp: price table, best value and first cut tables, fill and walk counters, output register
// depends on rcmv_pkg; commanded by rcmv_ctrl
module rcmv_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rcmv_pkg::rcmv_cmd_t                 cmd,
	output rcmv_pkg::rcmv_sts_t                 sts,
	input  logic [rcmv_pkg::LEN_W-1:0]          piece_length,
	input  logic [rcmv_pkg::IN_PRICE_W-1:0]     piece_price,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rcmv_pkg::LEN_W-1:0]          cut_length,
	output logic [rcmv_pkg::VALUE_BITS-1:0]     best_value,
	output logic [rcmv_pkg::LEN_W-1:0]          piece_count,
	output logic                                last
);

	logic [rcmv_pkg::PRICE_BITS-1:0] price_q [rcmv_pkg::MAX_PIECE];
	logic [rcmv_pkg::VALUE_BITS-1:0] best_q  [rcmv_pkg::MAX_ROD+1];
	logic [rcmv_pkg::K_W-1:0]        fcut_q  [rcmv_pkg::MAX_ROD+1];

	logic [rcmv_pkg::ROD_W-1:0]      rod_q;
	logic [rcmv_pkg::ROD_W-1:0]      n_q;
	logic [rcmv_pkg::K_W-1:0]        k_q;
	logic [rcmv_pkg::VALUE_BITS-1:0] bv_q;
	logic [rcmv_pkg::K_W-1:0]        bk_q;
	logic [rcmv_pkg::VALUE_BITS-1:0] total_q;
	logic [rcmv_pkg::ROD_W-1:0]      rem_q;
	logic [rcmv_pkg::ROD_W-1:0]      count_q;

	logic                            out_valid_q;
	logic [rcmv_pkg::LEN_W-1:0]      out_cut_q;
	logic [rcmv_pkg::VALUE_BITS-1:0] out_value_q;
	logic [rcmv_pkg::LEN_W-1:0]      out_count_q;
	logic                            out_last_q;

	logic [rcmv_pkg::ROD_W-1:0]      rod_d;
	logic [rcmv_pkg::K_W-1:0]        kmax;
	logic [rcmv_pkg::ROD_W-1:0]      back_idx;
	logic [rcmv_pkg::PIDX_W-1:0]     pidx;
	logic [rcmv_pkg::K_W-1:0]        k_dec;
	logic [rcmv_pkg::VALUE_BITS-1:0] best_rd;
	logic [rcmv_pkg::SUM_W-1:0]      sum;
	logic [rcmv_pkg::VALUE_BITS-1:0] cand;
	logic                            take;
	logic [rcmv_pkg::VALUE_BITS-1:0] bv_new;
	logic [rcmv_pkg::K_W-1:0]        bk_new;
	logic                            row_end;
	logic [rcmv_pkg::K_W-1:0]        fc_rd;
	logic [rcmv_pkg::CW-1:0]         cut;
	logic [rcmv_pkg::ROD_W-1:0]      cut_r;
	logic                            load_ok;

	// solve length saturates to the table size
	assign rod_d = (int'(piece_length) > rcmv_pkg::MAX_ROD) ? rcmv_pkg::ROD_MAX_V
		: rcmv_pkg::ROD_W'(piece_length);
	assign load_ok = (piece_length != '0) && (int'(piece_length) <= rcmv_pkg::MAX_PIECE);

	// one candidate cut per cycle
	assign kmax     = (rcmv_pkg::CW'(n_q) < rcmv_pkg::CW'(rcmv_pkg::KMAX_V))
		? rcmv_pkg::K_W'(n_q) : rcmv_pkg::KMAX_V;
	assign back_idx = n_q - rcmv_pkg::ROD_W'(k_q);
	assign k_dec    = k_q - rcmv_pkg::K_W'(1);
	assign pidx     = rcmv_pkg::PIDX_W'(k_dec);
	assign best_rd  = (back_idx == '0) ? '0 : best_q[back_idx];
	assign sum      = rcmv_pkg::SUM_W'(price_q[pidx]) + rcmv_pkg::SUM_W'(best_rd);
	assign cand     = (sum > rcmv_pkg::SUM_W'(rcmv_pkg::VALUE_MAX)) ? rcmv_pkg::VALUE_MAX
		: sum[rcmv_pkg::VALUE_BITS-1:0];
	assign take     = (k_q == rcmv_pkg::K_W'(1)) || (cand > bv_q);
	assign bv_new   = take ? cand : bv_q;
	assign bk_new   = take ? k_q : bk_q;
	assign row_end  = (k_q == kmax);

	// walk of the first cut chain
	assign fc_rd = fcut_q[rem_q];
	assign cut   = (fc_rd == '0 || rcmv_pkg::CW'(fc_rd) > rcmv_pkg::CW'(rem_q))
		? rcmv_pkg::CW'(rem_q) : rcmv_pkg::CW'(fc_rd);
	assign cut_r = rcmv_pkg::ROD_W'(cut);

	assign sts.dp_done  = row_end && (n_q == rod_q);
	assign sts.walk_end = (cut_r == rem_q);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rcmv_pkg::MAX_PIECE; i++) begin
				price_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && load_ok) begin
				price_q[rcmv_pkg::PIDX_W'(piece_length - rcmv_pkg::LEN_W'(1))] <=
					rcmv_pkg::PRICE_BITS'(piece_price);
			end
			if (cmd.emit_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rod_q   <= rod_d;
			rem_q   <= rod_d;
			n_q     <= rcmv_pkg::ROD_W'(1);
			k_q     <= rcmv_pkg::K_W'(1);
			count_q <= '0;
		end
		if (cmd.dp_step) begin
			if (row_end) begin
				best_q[n_q] <= bv_new;
				fcut_q[n_q] <= bk_new;
				n_q         <= n_q + rcmv_pkg::ROD_W'(1);
				k_q         <= rcmv_pkg::K_W'(1);
				if (n_q == rod_q) begin
					total_q <= bv_new;
				end
			end else begin
				k_q <= k_q + rcmv_pkg::K_W'(1);
			end
			bv_q <= bv_new;
			bk_q <= bk_new;
		end
		if (cmd.count_step) begin
			count_q <= count_q + rcmv_pkg::ROD_W'(1);
			rem_q   <= sts.walk_end ? rod_q : rem_q - cut_r;
		end
		if (cmd.emit_step) begin
			rem_q       <= rem_q - cut_r;
			out_cut_q   <= rcmv_pkg::LEN_W'(cut);
			out_value_q <= total_q;
			out_count_q <= rcmv_pkg::LEN_W'(count_q);
			out_last_q  <= sts.walk_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign cut_length  = out_cut_q;
	assign best_value  = out_value_q;
	assign piece_count = out_count_q;
	assign last        = out_last_q;

`ifndef ASSERT_OFF
	a_k_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dp_step |-> (k_q != '0) && (rcmv_pkg::CW'(k_q) <= rcmv_pkg::CW'(n_q)))
		else $error("candidate cut outside current row");
	a_walk_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.count_step || cmd.emit_step) |-> (rem_q != '0) && (cut != '0))
		else $error("walk with nothing left");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> !out_valid_q || out_ready)
		else $error("output word overwritten");
`endif

endmodule

>>> hw/rtl/rod_cutting_max_value_top.sv
// rod_cutting_max_value_top: best rod cutting by dynamic programming
// Input word (op, piece_length, piece_price) on in_valid/in_ready; output word
// (cut_length, best_value, piece_count, last) on out_valid/out_ready.
// op load writes a piece price and gives no output word.
// op solve of length L (saturated to 16, zero ignored) fills the table rows
// n=1..L, trying min(n,16) candidate cuts per row, one candidate
// cut per cycle through a single add and compare, then walks the first cut
// chain once to count the P pieces, then emits P words, one per cycle while
// out_ready is high, the final one with last set.
// in_ready is high only while no solve is in progress; a load or the next
// solve may be taken while the final word still waits in the output register.
// A receiver stall holds the output word and pauses emission.
// Reset clears the price table (unpriced lengths count as zero) and the
// controller; the best value and first cut tables are rebuilt by each solve.
// depends on rcmv_pkg, rcmv_ctrl, rcmv_dp
module rod_cutting_max_value_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                op,
	input  logic [rcmv_pkg::LEN_W-1:0]          piece_length,
	input  logic [rcmv_pkg::IN_PRICE_W-1:0]     piece_price,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rcmv_pkg::LEN_W-1:0]          cut_length,
	output logic [rcmv_pkg::VALUE_BITS-1:0]     best_value,
	output logic [rcmv_pkg::LEN_W-1:0]          piece_count,
	output logic                                last
);

	rcmv_pkg::rcmv_cmd_t cmd;
	rcmv_pkg::rcmv_sts_t sts;

	rcmv_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.piece_length (piece_length),
		.sts          (sts),
		.cmd          (cmd)
	);

	rcmv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.piece_length (piece_length),
		.piece_price  (piece_price),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cut_length   (cut_length),
		.best_value   (best_value),
		.piece_count  (piece_count),
		.last         (last)
	);

endmodule

>>> tb/rod_cutting_max_value_top_tb.sv
// rod_cutting_max_value_top_tb: self-checking bench for the rod cutting block, with price
// loads and solves from a queue, a predictor and a word-by-word check of every cut word
// depends on rcmv_pkg and rod_cutting_max_value_top
module rod_cutting_max_value_top_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 600;
	localparam int RANDOM_PER_PHASE = 70;

	typedef struct {
		logic                            op;
		logic [rcmv_pkg::LEN_W-1:0]      len;
		logic [rcmv_pkg::IN_PRICE_W-1:0] price;
	} in_word_t;

	typedef struct {
		logic [rcmv_pkg::LEN_W-1:0]      cut;
		logic [rcmv_pkg::VALUE_BITS-1:0] value;
		logic [rcmv_pkg::LEN_W-1:0]      count;
		logic                            last;
	} cut_word_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = 1'b0;
	logic [rcmv_pkg::LEN_W-1:0] piece_length = '0;
	logic [rcmv_pkg::IN_PRICE_W-1:0] piece_price = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [rcmv_pkg::LEN_W-1:0] cut_length;
	logic [rcmv_pkg::VALUE_BITS-1:0] best_value;
	logic [rcmv_pkg::LEN_W-1:0] piece_count;
	logic last;

	in_word_t words_to_send[$];
	cut_word_t cut_words_exp[$];
	logic [rcmv_pkg::PRICE_BITS-1:0] price_shadow[rcmv_pkg::MAX_PIECE];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_arm = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	bit in_took = 1'b0;
	int mismatches = 0;
	int cycles = 0;

	rod_cutting_max_value_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.piece_length (piece_length),
		.piece_price  (piece_price),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cut_length   (cut_length),
		.best_value   (best_value),
		.piece_count  (piece_count),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic apply_word(in_word_t w);
		logic [rcmv_pkg::VALUE_BITS-1:0] best[rcmv_pkg::MAX_ROD+1];
		int first[rcmv_pkg::MAX_ROD+1];
		logic [rcmv_pkg::VALUE_BITS:0] s;
		logic [rcmv_pkg::VALUE_BITS-1:0] bv;
		int cuts[$];
		int rod, n, k, kmax, bk, rem;
		cut_word_t c;
		if (w.op == rcmv_pkg::OP_LOAD) begin
			if (w.len >= 1 && w.len <= rcmv_pkg::MAX_PIECE)
				price_shadow[rcmv_pkg::PIDX_W'(w.len - 1'b1)] =
					w.price[rcmv_pkg::PRICE_BITS-1:0];
		end else if (w.len != 0) begin
			rod = (w.len > rcmv_pkg::MAX_ROD) ? rcmv_pkg::MAX_ROD : int'(w.len);
			best[0] = '0;
			first[0] = 0;
			for (n = 1; n <= rod; n++) begin
				bv = '0;
				bk = 0;
				kmax = (n < rcmv_pkg::MAX_PIECE) ? n : rcmv_pkg::MAX_PIECE;
				// ascending k with strict compare: smallest first cut wins ties
				for (k = 1; k <= kmax; k++) begin
					s = {1'b0, best[n-k]} + price_shadow[k-1];
					if (s > rcmv_pkg::VALUE_MAX)
						s = {1'b0, rcmv_pkg::VALUE_MAX};
					if (k == 1 || s[rcmv_pkg::VALUE_BITS-1:0] > bv) begin
						bv = s[rcmv_pkg::VALUE_BITS-1:0];
						bk = k;
					end
				end
				best[n] = bv;
				first[n] = bk;
			end
			rem = rod;
			while (rem > 0 && cuts.size() < rcmv_pkg::MAX_ROD) begin
				k = first[rem];
				if (k == 0 || k > rem)
					k = rem;
				cuts.push_back(k);
				rem -= k;
			end
			foreach (cuts[i]) begin
				c.cut = rcmv_pkg::LEN_W'(cuts[i]);
				c.value = best[rod];
				c.count = rcmv_pkg::LEN_W'(cuts.size());
				c.last = (i == cuts.size() - 1);
				cut_words_exp.push_back(c);
			end
		end
	endtask

	always @(negedge clk) begin : drive_in
		in_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (words_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				w = words_to_send.pop_front();
				in_valid <= 1'b1;
				op <= w.op;
				piece_length <= w.len;
				piece_price <= w.price;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : watch
		in_word_t w;
		cut_word_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			in_took = arst_n && in_valid && in_ready;
			if (in_took) begin
				w.op = op;
				w.len = piece_length;
				w.price = piece_price;
				apply_word(w);
			end
			if (arst_n && out_valid && out_ready) begin
				if (cut_words_exp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: unexpected word cut %0d value %0d count %0d last %0d",
							cut_length, best_value, piece_count, last);
				end else begin
					e = cut_words_exp.pop_front();
					if (cut_length !== e.cut || best_value !== e.value ||
						piece_count !== e.count || last !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("tb: mismatch cut %0d/%0d value %0d/%0d count %0d/%0d last %0d/%0d",
								e.cut, cut_length, e.value, best_value,
								e.count, piece_count, e.last, last);
					end
				end
			end
		end
	end

	initial begin : stimulus
		in_word_t w;
		int r;
		foreach (price_shadow[i])
			price_shadow[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 33;
		rx_idle_pct = 48;
		// unpriced lengths, ignored loads, zero and oversize rods, ties, longest cutting
		words_to_send.push_back('{rcmv_pkg::OP_SOLVE, 5'd5, 16'hFFFF});
		words_to_send.push_back('{rcmv_pkg::OP_SOLVE, 5'd0, 16'h0000});
		words_to_send.push_back('{rcmv_pkg::OP_LOAD, 5'd0, 16'hFFFF});
		words_to_send.push_back('{rcmv_pkg::OP_LOAD, 5'd17, 16'hFFFF});
		words_to_send.push_back('{rcmv_pkg::OP_LOAD, 5'd31, 16'h1234});
		words_to_send.push_back('{rcmv_pkg::OP_LOAD, 5'd16, 16'hFFFF});
		words_to_send.push_back('{rcmv_pkg::OP_LOAD, 5'd1, 16'h0000});
		words_to_send.push_back('{rcmv_pkg::OP_SOLVE, 5'd16, 16'h0000});
		words_to_send.push_back('{rcmv_pkg::OP_SOLVE, 5'd31, 16'hFFFF});
		words_to_send.push_back('{rcmv_pkg::OP_SOLVE, 5'd1, 16'h5A5A});
		words_to_send.push_back('{rcmv_pkg::OP_LOAD, 5'd1, 16'd10});
		words_to_send.push_back('{rcmv_pkg::OP_LOAD, 5'd2, 16'd20});
		words_to_send.push_back('{rcmv_pkg::OP_LOAD, 5'd3, 16'd35});
		words_to_send.push_back('{rcmv_pkg::OP_SOLVE, 5'd4, 16'hA5A5});
		words_to_send.push_back('{rcmv_pkg::OP_LOAD, 5'd1, 16'hFFFF});
		words_to_send.push_back('{rcmv_pkg::OP_SOLVE, 5'd16, 16'h0000});
		words_to_send.push_back('{rcmv_pkg::OP_SOLVE, 5'd17, 16'h0000});
		words_to_send.push_back('{rcmv_pkg::OP_LOAD, 5'd16, 16'h0000});
		words_to_send.push_back('{rcmv_pkg::OP_SOLVE, 5'd15, 16'h0F0F});

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				tx_idle_pct = 48;
				rx_idle_pct = 33;
			end else if (phase == 2) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				hold_arm = 1'b1;
			end
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				r = $urandom_range(9);
				if (r == 0)
					w.price = '0;
				else if (r == 1)
					w.price = '1;
				else if (r < 5)
					w.price = rcmv_pkg::IN_PRICE_W'($urandom_range(50));
				else
					w.price = rcmv_pkg::IN_PRICE_W'($urandom);
				if ($urandom_range(99) < 55) begin
					w.op = rcmv_pkg::OP_LOAD;
					if ($urandom_range(9) == 0)
						w.len = $urandom_range(1) ? rcmv_pkg::LEN_W'(0)
							: rcmv_pkg::LEN_W'($urandom_range(17, 31));
					else
						w.len = rcmv_pkg::LEN_W'($urandom_range(1, 16));
				end else begin
					w.op = rcmv_pkg::OP_SOLVE;
					r = $urandom_range(19);
					if (r == 0)
						w.len = '0;
					else if (r == 1)
						w.len = rcmv_pkg::LEN_W'($urandom_range(17, 31));
					else if (r < 5)
						w.len = rcmv_pkg::LEN_W'(16);
					else
						w.len = rcmv_pkg::LEN_W'($urandom_range(1, 10));
				end
				words_to_send.push_back(w);
			end
			while (words_to_send.size() != 0 || in_valid)
				@(posedge clk);
		end

		while (cut_words_exp.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
